@@ src/tpm_pkg.sv @@
// types and constants shared by the triac phase mode machine
package tpm_pkg;

	// channel modes
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_SYM  = 2'd2,
		MODE_ASYM = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_PHASE_GUARD = 1'b0,
		CFG_ENABLE_MASK = 1'b1
	} cfg_idx_t;

	localparam int CFG_DATA_W = 8;
	localparam int GUARD_W    = 7;
	localparam int MASK_W     = 8;
	localparam int CHAN_W     = 3;
	localparam int ANGLE_W    = 8;

	localparam logic [GUARD_W-1:0] GUARD_RESET = 7'd3;
	localparam logic [MASK_W-1:0]  MASK_RESET  = 8'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 8'd180;
	localparam logic [ANGLE_W-1:0] ANGLE_ZERO  = 8'd0;

	// request transaction
	typedef struct packed {
		logic [CHAN_W-1:0]  channel;
		logic [ANGLE_W-1:0] pos_angle;
		logic [ANGLE_W-1:0] neg_angle;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic               issue;
		logic [ANGLE_W-1:0] cmd_pos;
		logic [ANGLE_W-1:0] cmd_neg;
		mode_t              mode;
	} out_item_t;

	// outcome of the transition rules for one request
	typedef struct packed {
		logic               change;
		mode_t              next;
		logic [ANGLE_W-1:0] cmd_pos;
		logic [ANGLE_W-1:0] cmd_neg;
	} decision_t;

endpackage

@@ src/tpm_stream_if.sv @@
// valid/ready stream channel carrying one payload type
interface tpm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/tpm_ram.sv @@
// generic single-write, single-read ram with registered read data
module tpm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ src/tpm_decide.sv @@
// guard-band transition rules and firing command for one channel
module tpm_decide (
	input  tpm_pkg::mode_t                  cur,
	input  logic [tpm_pkg::ANGLE_W-1:0]     pos_angle,
	input  logic [tpm_pkg::ANGLE_W-1:0]     neg_angle,
	input  logic [tpm_pkg::GUARD_W-1:0]     guard,
	output tpm_pkg::decision_t              dec
);
	import tpm_pkg::*;

	logic [ANGLE_W-1:0] lo;
	logic [ANGLE_W-1:0] hi;
	logic               p_mid;
	logic               both_hi;
	logic               both_lo;
	logic               same;
	mode_t              next;

	// snap an angle near either edge onto that edge
	function automatic logic [ANGLE_W-1:0] clamp_edge(
		input logic [ANGLE_W-1:0] a,
		input logic [ANGLE_W-1:0] l,
		input logic [ANGLE_W-1:0] h
	);
		logic [ANGLE_W-1:0] r;
		if (a <= l) begin
			r = ANGLE_ZERO;
		end else if (a >= h) begin
			r = ANGLE_FULL;
		end else begin
			r = a;
		end
		return r;
	endfunction

	// thresholds and band tests
	assign lo      = ANGLE_W'(guard);
	assign hi      = ANGLE_FULL - lo;
	assign p_mid   = (pos_angle < hi) && (pos_angle > lo);
	assign both_hi = (pos_angle >= hi) && (neg_angle >= hi);
	assign both_lo = (pos_angle <= lo) && (neg_angle <= lo);
	assign same    = (pos_angle == neg_angle);

	// mode transition
	always_comb begin
		next = cur;
		unique case (cur)
			MODE_OFF: begin
				if (both_hi) next = MODE_ON;
				else if (p_mid) next = same ? MODE_SYM : MODE_ASYM;
			end
			MODE_ON: begin
				if (both_lo) next = MODE_OFF;
				else if (p_mid) next = same ? MODE_SYM : MODE_ASYM;
			end
			MODE_SYM: begin
				if (both_lo) next = MODE_OFF;
				else if (both_hi) next = MODE_ON;
				else if (!same) next = MODE_ASYM;
			end
			default: begin
				if (both_lo) next = MODE_OFF;
				else if (both_hi) next = MODE_ON;
				else if (p_mid && same) next = MODE_SYM;
			end
		endcase
	end

	// firing command on a mode change
	always_comb begin
		dec.change  = (next != cur);
		dec.next    = next;
		dec.cmd_pos = ANGLE_ZERO;
		dec.cmd_neg = ANGLE_ZERO;
		if (dec.change) begin
			unique case (next)
				MODE_OFF: begin
					dec.cmd_pos = ANGLE_ZERO;
					dec.cmd_neg = ANGLE_ZERO;
				end
				MODE_ON: begin
					dec.cmd_pos = ANGLE_FULL;
					dec.cmd_neg = ANGLE_FULL;
				end
				MODE_SYM: begin
					dec.cmd_pos = pos_angle;
					dec.cmd_neg = pos_angle;
				end
				default: begin
					dec.cmd_pos = clamp_edge(pos_angle, lo, hi);
					dec.cmd_neg = clamp_edge(neg_angle, lo, hi);
				end
			endcase
		end
	end
endmodule

@@ src/triac_phase_mode_machine.sv @@
// top level of the triac phase mode machine
//
//  channel   dir   payload                              transaction when
//  in_ch     in    channel, pos_angle, neg_angle        in_ch.valid && in_ch.ready
//  out_ch    out   issue, cmd_pos, cmd_neg, mode        out_ch.valid && out_ch.ready
//  cfg       in    cfg_we, cfg_idx, cfg_wdata           cfg_we
//
// one request per cycle sustained while the output is not stalled; a result passes the decide
// stage register (with the registered mode ram read) and the decide/write-back stage to the output register
// a write in the previous cycle to the same channel is forwarded past the ram
// reset marks every channel off through per-entry valid flops, no clearing pass
// a stalled output holds the decide stage, which in turn holds off new requests
module triac_phase_mode_machine #(
	parameter int CHANNELS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tpm_stream_if.sink                       in_ch,
	tpm_stream_if.source                     out_ch,
	input  logic                             cfg_we,
	input  tpm_pkg::cfg_idx_t                cfg_idx,
	input  logic [tpm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import tpm_pkg::*;

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IW    = (AW > CHAN_W) ? AW : CHAN_W;
	localparam int SLOTS = 2 ** AW;

	logic [GUARD_W-1:0] guard_q;
	logic [MASK_W-1:0]  mask_q;

	logic               accept;
	logic [IW-1:0]      ch_in_ext;
	logic               valid_s1;
	in_item_t           item_s1;
	logic               adv_s1;
	logic [IW-1:0]      ch_ext_s1;
	logic [AW-1:0]      addr_s1;
	logic               in_range_s1;
	logic               enabled_s1;

	logic [1:0]         rdata;
	logic [SLOTS-1:0]   ent_valid_q;
	logic               wr_valid_q;
	logic [AW-1:0]      wr_addr_q;
	mode_t              wr_mode_q;
	mode_t              cur_s1;
	decision_t          dec_s1;
	logic               wr_en;

	logic               out_valid_q;
	out_item_t          out_item_q;
	out_item_t          result_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= GUARD_RESET;
			mask_q  <= MASK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PHASE_GUARD: guard_q <= cfg_wdata[GUARD_W-1:0];
				CFG_ENABLE_MASK: mask_q  <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// input handshake
	assign adv_s1      = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign ch_in_ext   = IW'(in_ch.data.channel);

	// decide stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_ch.data;
		end
	end

	// mode storage
	tpm_ram #(
		.WIDTH (2),
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_mode_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (dec_s1.next),
		.re    (accept),
		.raddr (ch_in_ext[AW-1:0]),
		.rdata (rdata)
	);

	// channel decode in the decide stage
	assign ch_ext_s1   = IW'(item_s1.channel);
	assign addr_s1     = ch_ext_s1[AW-1:0];
	assign in_range_s1 = {1'b0, ch_ext_s1} < (IW+1)'(CHANNELS);
	assign enabled_s1  = mask_q[item_s1.channel];

	// current mode: forwarded write, else off when never written, else ram
	always_comb begin
		if (wr_valid_q && (wr_addr_q == addr_s1)) begin
			cur_s1 = wr_mode_q;
		end else if (!ent_valid_q[addr_s1]) begin
			cur_s1 = MODE_OFF;
		end else begin
			cur_s1 = mode_t'(rdata);
		end
	end

	tpm_decide u_decide (
		.cur       (cur_s1),
		.pos_angle (item_s1.pos_angle),
		.neg_angle (item_s1.neg_angle),
		.guard     (guard_q),
		.dec       (dec_s1)
	);

	assign wr_en = valid_s1 && adv_s1 && in_range_s1 && enabled_s1 && dec_s1.change;

	// entry valid flops and last-write forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			wr_valid_q  <= 1'b0;
			wr_addr_q   <= '0;
			wr_mode_q   <= MODE_OFF;
		end else if (wr_en) begin
			ent_valid_q[addr_s1] <= 1'b1;
			wr_valid_q           <= 1'b1;
			wr_addr_q            <= addr_s1;
			wr_mode_q            <= dec_s1.next;
		end
	end

	// result assembly
	always_comb begin
		result_s1.issue   = 1'b0;
		result_s1.cmd_pos = ANGLE_ZERO;
		result_s1.cmd_neg = ANGLE_ZERO;
		result_s1.mode    = MODE_OFF;
		if (in_range_s1) begin
			if (!enabled_s1) begin
				result_s1.mode = cur_s1;
			end else begin
				result_s1.issue   = dec_s1.change;
				result_s1.cmd_pos = dec_s1.cmd_pos;
				result_s1.cmd_neg = dec_s1.cmd_neg;
				result_s1.mode    = dec_s1.next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_item_q <= result_s1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_item_q;

`ifndef SYNTHESIS
	a_no_issue_zero_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_item_q.issue |->
			out_item_q.cmd_pos == ANGLE_ZERO && out_item_q.cmd_neg == ANGLE_ZERO)
		else $error("result without command carries nonzero angles");

	a_on_full_angles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.issue && out_item_q.mode == MODE_ON |->
			out_item_q.cmd_pos == ANGLE_FULL && out_item_q.cmd_neg == ANGLE_FULL)
		else $error("switch to on without full angles");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("decide stage lost its request during a stall");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> ent_valid_q[$past(addr_s1)] && wr_valid_q)
		else $error("mode write not recorded");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> in_range_s1 && enabled_s1)
		else $error("mode write for an ignored channel");
`endif
endmodule

@@ sim/triac_phase_mode_machine_tb.sv @@
// self-checking testbench for the triac phase mode machine
module triac_phase_mode_machine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpm_pkg::*;

	localparam int CHANNELS        = 8;
	localparam int RESET_CYCLES    = 12;
	localparam int DRAIN_CYCLES    = 4;
	localparam int IDLE_LIMIT      = 5000;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 220;

	// tracks channel modes and the results still owed by the block
	class firing_scoreboard;
		mode_t              chan_mode [CHANNELS];
		logic [GUARD_W-1:0] guard;
		logic [MASK_W-1:0]  mask;
		out_item_t          expected_firings [$];
		int                 errors;

		function new();
			foreach (chan_mode[c])
				chan_mode[c] = MODE_OFF;
			guard  = GUARD_RESET;
			mask   = MASK_RESET;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			if (idx == CFG_PHASE_GUARD)
				guard = value[GUARD_W-1:0];
			else
				mask = value[MASK_W-1:0];
		endfunction

		// angles near the edges snap to 0 or full in asymmetric mode
		function logic [ANGLE_W-1:0] clamp_angle(int a, int lo, int hi);
			if (a <= lo)
				return ANGLE_ZERO;
			if (a >= hi)
				return ANGLE_FULL;
			return a[ANGLE_W-1:0];
		endfunction

		// apply the guard-band transition rules to one accepted request
		function void note_request(in_item_t req);
			out_item_t e;
			mode_t     cur;
			mode_t     nxt;
			int        lo;
			int        hi;
			int        p;
			int        n;
			bit        p_mid;
			bit        both_hi;
			bit        both_lo;

			e   = '0;
			cur = chan_mode[req.channel];
			if (!mask[req.channel]) begin
				e.mode = cur;
				expected_firings.push_back(e);
				return;
			end
			lo      = guard;
			hi      = 180 - int'(guard);
			p       = req.pos_angle;
			n       = req.neg_angle;
			p_mid   = (p < hi) && (p > lo);
			both_hi = (p >= hi) && (n >= hi);
			both_lo = (p <= lo) && (n <= lo);
			nxt     = cur;
			case (cur)
				MODE_OFF: begin
					if (both_hi)
						nxt = MODE_ON;
					else if (p_mid)
						nxt = (n == p) ? MODE_SYM : MODE_ASYM;
				end
				MODE_ON: begin
					if (both_lo)
						nxt = MODE_OFF;
					else if (p_mid)
						nxt = (n == p) ? MODE_SYM : MODE_ASYM;
				end
				MODE_SYM: begin
					if (both_lo)
						nxt = MODE_OFF;
					else if (both_hi)
						nxt = MODE_ON;
					else if (p != n)
						nxt = MODE_ASYM;
				end
				default: begin
					if (both_lo)
						nxt = MODE_OFF;
					else if (both_hi)
						nxt = MODE_ON;
					else if (p_mid && n == p)
						nxt = MODE_SYM;
				end
			endcase
			// a firing command goes out only on a mode change
			if (nxt != cur) begin
				e.issue = 1'b1;
				case (nxt)
					MODE_OFF: begin
						e.cmd_pos = ANGLE_ZERO;
						e.cmd_neg = ANGLE_ZERO;
					end
					MODE_ON: begin
						e.cmd_pos = ANGLE_FULL;
						e.cmd_neg = ANGLE_FULL;
					end
					MODE_SYM: begin
						e.cmd_pos = req.pos_angle;
						e.cmd_neg = req.pos_angle;
					end
					default: begin
						e.cmd_pos = clamp_angle(p, lo, hi);
						e.cmd_neg = clamp_angle(n, lo, hi);
					end
				endcase
				chan_mode[req.channel] = nxt;
			end
			e.mode = nxt;
			expected_firings.push_back(e);
		endfunction

		// compare one result with the oldest expected firing
		function void check_result(out_item_t got);
			out_item_t e;

			if (expected_firings.size() == 0) begin
				$error("result with no request pending: issue %0d pos %0d neg %0d mode %0d",
					got.issue, got.cmd_pos, got.cmd_neg, got.mode);
				errors++;
				return;
			end
			e = expected_firings.pop_front();
			if (got.issue !== e.issue) begin
				$error("issue: expected %0d, got %0d", e.issue, got.issue);
				errors++;
			end
			if (got.cmd_pos !== e.cmd_pos) begin
				$error("cmd_pos: expected %0d, got %0d", e.cmd_pos, got.cmd_pos);
				errors++;
			end
			if (got.cmd_neg !== e.cmd_neg) begin
				$error("cmd_neg: expected %0d, got %0d", e.cmd_neg, got.cmd_neg);
				errors++;
			end
			if (got.mode !== e.mode) begin
				$error("mode: expected %0d, got %0d", e.mode, got.mode);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tpm_stream_if #(.T(in_item_t))  req_if ();
	tpm_stream_if #(.T(out_item_t)) res_if ();

	firing_scoreboard firing_sb = new();

	int idle_cycles;
	int burst_left;
	int stall_cycle;
	int stall_style;

	triac_phase_mode_machine #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_if),
		.out_ch    (res_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls, switching style every so often
	always @(posedge clk) begin
		stall_cycle++;
		if (stall_cycle % 97 == 0)
			stall_style = $urandom_range(3, 0);
		case (stall_style)
			0:       res_if.ready <= 1'b1;
			1:       res_if.ready <= 1'($urandom_range(1, 0));
			2:       res_if.ready <= (stall_cycle % 16) < 8;
			default: res_if.ready <= $urandom_range(7, 0) != 0;
		endcase
	end

	// transaction monitors and watchdog
	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready)
			firing_sb.note_request(req_if.data);
		if (arst_n && res_if.valid && res_if.ready)
			firing_sb.check_result(res_if.data);
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("triac_phase_mode_machine verification failed");
			$finish;
		end
	end

	function automatic in_item_t mk_req(int ch, int p, int n);
		in_item_t r;

		r.channel   = ch[CHAN_W-1:0];
		r.pos_angle = p[ANGLE_W-1:0];
		r.neg_angle = n[ANGLE_W-1:0];
		return r;
	endfunction

	// angle biased toward the guard bands, their edges, the mid range and values past full
	function automatic logic [ANGLE_W-1:0] pick_angle(int g);
		int hi;

		hi = 180 - g;
		case ($urandom_range(5, 0))
			0: return 8'($urandom_range(g + 1, 0));
			1: return 8'($urandom_range(180, hi - 1));
			2: return 8'($urandom_range(255, 0));
			3: return 8'($urandom_range(255, 181));
			4: begin
				case ($urandom_range(5, 0))
					0:       return 8'(g);
					1:       return 8'(g + 1);
					2:       return 8'(hi - 1);
					3:       return 8'(hi);
					4:       return ANGLE_ZERO;
					default: return ANGLE_FULL;
				endcase
			end
			default: begin
				if (g + 1 <= hi - 1)
					return 8'($urandom_range(hi - 1, g + 1));
				return 8'($urandom_range(255, 0));
			end
		endcase
	endfunction

	function automatic in_item_t random_req();
		in_item_t r;
		int       g;

		g           = firing_sb.guard;
		r.channel   = CHAN_W'($urandom_range(CHANNELS - 1, 0));
		r.pos_angle = pick_angle(g);
		if ($urandom_range(9, 0) < 4)
			r.neg_angle = r.pos_angle;
		else
			r.neg_angle = pick_angle(g);
		return r;
	endfunction

	// sender: bursts of random length with random gaps
	task automatic send_request(input in_item_t r);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	// hold off until every expected result is back, then let the pipe empty
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (firing_sb.expected_firings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] guard_val,
		input logic [CFG_DATA_W-1:0] mask_val);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_PHASE_GUARD;
		cfg_wdata <= guard_val;
		@(posedge clk);
		cfg_idx   <= CFG_ENABLE_MASK;
		cfg_wdata <= mask_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		firing_sb.set_reg(CFG_PHASE_GUARD, guard_val);
		firing_sb.set_reg(CFG_ENABLE_MASK, mask_val);
		@(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [CFG_DATA_W-1:0] guard_val;
		logic [CFG_DATA_W-1:0] mask_val;
		int                    count;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_PHASE_GUARD;
		cfg_wdata    = '0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		res_if.ready = 1'b0;
		idle_cycles  = 0;
		burst_left   = 0;
		stall_cycle  = 0;
		stall_style  = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every channel disabled
		repeat (6) send_request(random_req());
		settle();

		// mode transitions with the default guard
		apply_config(8'd3, 8'hFF);
		send_request(mk_req(0, 0, 0));
		send_request(mk_req(0, 180, 180));
		send_request(mk_req(0, 90, 90));
		send_request(mk_req(0, 90, 100));
		send_request(mk_req(0, 90, 90));
		send_request(mk_req(0, 2, 90));
		send_request(mk_req(0, 0, 3));
		send_request(mk_req(1, 90, 2));
		send_request(mk_req(2, 90, 200));
		send_request(mk_req(3, 100, 255));
		send_request(mk_req(4, 255, 255));
		send_request(mk_req(4, 4, 4));
		send_request(mk_req(4, 200, 181));
		send_request(mk_req(4, 0, 0));
		send_request(mk_req(5, 3, 177));
		send_request(mk_req(5, 177, 177));
		send_request(mk_req(5, 176, 176));
		send_request(mk_req(5, 4, 9));
		send_request(mk_req(7, 255, 0));
		settle();

		// disabled channels keep their mode, an enabled one still changes
		apply_config(8'd3, 8'h0F);
		send_request(mk_req(5, 180, 180));
		send_request(mk_req(7, 90, 90));
		send_request(mk_req(2, 0, 0));
		settle();

		// guard past 89: thresholds cross over
		apply_config(8'd127, 8'hFF);
		send_request(mk_req(6, 100, 100));
		send_request(mk_req(6, 50, 50));
		send_request(mk_req(6, 127, 128));
		settle();

		// random phases over several settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			count    = ITEMS_PER_PHASE;
			mask_val = 8'($urandom_range(255, 0) | $urandom_range(255, 0));
			case (ph)
				0: begin
					guard_val = 8'd0;
					mask_val  = 8'hFF;
				end
				1: begin
					guard_val = 8'd89;
					mask_val  = 8'hFF;
				end
				2: guard_val = 8'd127;
				3: guard_val = 8'($urandom_range(255, 128));
				4: begin
					guard_val = 8'($urandom_range(89, 0));
					mask_val  = 8'h00;
					count     = 40;
				end
				5: guard_val = 8'($urandom_range(10, 0));
				default: guard_val = 8'($urandom_range(89, 0));
			endcase
			apply_config(guard_val, mask_val);
			repeat (count) send_request(random_req());
			settle();
		end

		if (firing_sb.errors == 0 && firing_sb.expected_firings.size() == 0)
			$display("triac_phase_mode_machine verification clean");
		else
			$display("triac_phase_mode_machine verification failed");
		$finish;
	end

endmodule
